### rtl/core/swiw_pkg.sv
package swiw_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int SINE_BITS_DEF  = 10;

   // field widths
   localparam int COORD_W    = 10;
   localparam int PIXEL_W    = 32;
   localparam int AMP_W      = 13;
   localparam int ANGLE_W    = 16;
   localparam int DIM_W      = 9;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 56;

   // displacement arithmetic: Q1.15 sine times Q8.4 amplitude gives Q19
   localparam int SINE_W    = 16;
   localparam int SINE_FRAC = 15;
   localparam int PROD_W    = AMP_W + SINE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int FRAC_BITS = 19;
   localparam int SHIFT_W   = SUM_W - FRAC_BITS;
   // a coordinate plus the widest shift, signed
   localparam int SHIFTED_W = COORD_W + 2;

   localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hFF00_0000;

   // result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

   // sine table generation constants
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint unsigned Q30_ONE    = 64'd1 << 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_AMPLITUDE    = 3'd0,
      REG_WAVE_STEP    = 3'd1,
      REG_PHASE_OFFSET = 3'd2,
      REG_VERTICAL     = 3'd3,
      REG_SRC_WIDTH    = 3'd4,
      REG_SRC_HEIGHT   = 3'd5,
      REG_HAS_ALPHA    = 3'd6
   } csr_reg_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_FETCH = 1'b1
   } func_type;

   typedef struct packed {
      func_type               func;
      logic [COORD_W-1:0]     x;
      logic [COORD_W-1:0]     y;
      logic [PIXEL_W-1:0]     pix;
   } swiw_item_type;

   typedef struct packed {
      logic signed [AMP_W-1:0] amplitude;
      logic [ANGLE_W-1:0]      wave_step;
      logic [ANGLE_W-1:0]      phase_offset;
      logic                    vertical_mode;
      logic [DIM_W-1:0]        source_width;
      logic [DIM_W-1:0]        source_height;
      logic                    has_alpha;
   } swiw_cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               covered;
   } swiw_result_type;

   // one sine table entry in Q1.15, built from a truncated Taylor series in Q30
   function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k, int unsigned bits);
      longint unsigned n;
      longint unsigned quarter;
      longint unsigned q;
      longint unsigned r;
      longint unsigned p;
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      logic signed [SINE_W-1:0] mag;
      n       = 64'd1 << bits;
      quarter = n >> 2;
      q       = (longint'(k) & (n - 1)) >> (bits - 2);
      r       = longint'(k) & (quarter - 1);
      p       = q[0] ? quarter - r : r;
      theta   = (p * TWO_PI_Q30) >> bits;
      x2      = (theta * theta) >> 30;
      t       = Q30_ONE;
      t       = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t       = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t       = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t       = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t       = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s       = (theta * t) >> 30;
      v       = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      mag = $signed(SINE_W'(v));
      return (q >= 2) ? -mag : mag;
   endfunction

endpackage

### rtl/core/swiw_wave.sv
module swiw_wave
   import swiw_pkg::*;
#(
   parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  swiw_item_type               in_item,
   input  swiw_cfg_type                cfg,
   output logic                        out_valid,
   output swiw_item_type               out_item,
   output logic signed [SHIFT_W-1:0]   out_shift
);

   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   // sine rom, full period
   logic signed [SINE_W-1:0] sine_rom [SINE_N];

   for (genvar g = 0; g < SINE_N; g++) begin : g_rom
      assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
   end

   logic                               v1_ff, v2_ff, v3_ff, v4_ff;
   swiw_item_type                      item1_ff, item2_ff, item3_ff, item4_ff;
   logic [COORD_W-1:0]                 line;
   logic [ANGLE_W+COORD_W-1:0]         step_prod;
   logic [ANGLE_W-1:0]                 angle;
   logic [SINE_TABLE_BITS-1:0]         angle_idx_in, angle_idx_ff;
   logic signed [SINE_W-1:0]           sine_ff, sine_sel;
   logic signed [PROD_W-1:0]           prod_in, prod_ff;
   logic signed [SUM_W-1:0]            sum_in;
   logic signed [SHIFT_W-1:0]          shift_in, shift_ff;

   // angle of the line this pixel sits on
   always_comb begin
      line         = cfg.vertical_mode ? in_item.y : in_item.x;
      step_prod    = cfg.wave_step * line;
      angle        = cfg.phase_offset + step_prod[ANGLE_W-1:0];
      angle_idx_in = angle[ANGLE_W-1 -: SINE_TABLE_BITS];
   end

   // amplitude times sine, negated for column shifting
   always_comb begin
      sine_sel = cfg.vertical_mode ? sine_ff : -sine_ff;
      prod_in  = $signed(cfg.amplitude) * sine_sel;
   end

   // round and floor to whole pixels
   always_comb begin
      sum_in   = SUM_W'(prod_ff) - (SUM_W'($signed(cfg.amplitude)) <<< SINE_FRAC) + ROUND_HALF;
      shift_in = SHIFT_W'(sum_in >>> FRAC_BITS);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      angle_idx_ff <= angle_idx_in;
      item1_ff     <= in_item;
      sine_ff      <= sine_rom[angle_idx_ff];
      item2_ff     <= item1_ff;
      prod_ff      <= prod_in;
      item3_ff     <= item2_ff;
      shift_ff     <= shift_in;
      item4_ff     <= item3_ff;
   end

   assign out_valid = v4_ff;
   assign out_item  = item4_ff;
   assign out_shift = shift_ff;

endmodule

### rtl/core/swiw_store.sv
module swiw_store
   import swiw_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  swiw_item_type               in_item,
   input  logic signed [SHIFT_W-1:0]   in_shift,
   input  swiw_cfg_type                cfg,
   output logic                        out_valid,
   output swiw_result_type             out_result
);

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int LIM_W   = $clog2(MAX_DIM + 1);
   localparam int CMP_W   = ((LIM_W > SHIFTED_W) ? LIM_W : SHIFTED_W) + 1;
   localparam logic signed [CMP_W-1:0] WIDTH_LIM  = CMP_W'(MAX_WIDTH);
   localparam logic signed [CMP_W-1:0] HEIGHT_LIM = CMP_W'(MAX_HEIGHT);
   localparam logic [ADDR_W-1:0]       ROW_PITCH  = ADDR_W'(MAX_WIDTH);

   logic [PIXEL_W-1:0]        frame_mem [DEPTH];

   logic signed [CMP_W-1:0]   x_raw, y_raw, shift_ext, x_src, y_src;
   logic signed [CMP_W-1:0]   src_w, src_h, w_lim, h_lim, col, row;
   logic                      is_fetch, covered, load_ok, mem_we, mem_re;
   logic [ADDR_W-1:0]         mem_addr;
   logic [PIXEL_W-1:0]        rd_data_ff;
   logic                      valid_ff, covered_ff;

   // displaced coordinate and coverage test
   always_comb begin
      x_raw     = $signed(CMP_W'(in_item.x));
      y_raw     = $signed(CMP_W'(in_item.y));
      shift_ext = CMP_W'(in_shift);
      x_src     = cfg.vertical_mode ? x_raw + shift_ext : x_raw;
      y_src     = cfg.vertical_mode ? y_raw : y_raw + shift_ext;
      src_w     = $signed(CMP_W'(cfg.source_width));
      src_h     = $signed(CMP_W'(cfg.source_height));
      w_lim     = (src_w > WIDTH_LIM) ? WIDTH_LIM : src_w;
      h_lim     = (src_h > HEIGHT_LIM) ? HEIGHT_LIM : src_h;
      covered   = !x_src[CMP_W-1] && (x_src < w_lim) && !y_src[CMP_W-1] && (y_src < h_lim);
      load_ok   = (x_raw < WIDTH_LIM) && (y_raw < HEIGHT_LIM);
      is_fetch  = (in_item.func == FUNC_FETCH);
   end

   // one store access per word, load or fetch, in arrival order
   always_comb begin
      col      = is_fetch ? x_src : x_raw;
      row      = is_fetch ? y_src : y_raw;
      mem_addr = ADDR_W'(row[ROW_W-1:0]) * ROW_PITCH + ADDR_W'(col[COL_W-1:0]);
      mem_we   = in_valid && !is_fetch && load_ok;
      mem_re   = in_valid && is_fetch && covered;
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_addr] <= in_item.pix;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[mem_addr];
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid && is_fetch;
      end
   end

   always_ff @(posedge clock) begin
      covered_ff <= covered;
   end

   // alpha forcing and zero fill
   always_comb begin
      out_result.covered = covered_ff;
      if (!covered_ff) begin
         out_result.pixel = '0;
      end else if (cfg.has_alpha) begin
         out_result.pixel = rd_data_ff;
      end else begin
         out_result.pixel = rd_data_ff | ALPHA_MASK;
      end
   end

   assign out_valid = valid_ff;

endmodule

### rtl/core/swiw_queue.sv
module swiw_queue
   import swiw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swiw_result_type   push_data,
   input  logic              pop,
   output logic              out_valid,
   output swiw_result_type   out_data
);

   swiw_result_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_W:0]       count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_W + 1)'(push) - (QUEUE_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

### rtl/core/sine_wave_image_warp.sv
// Sine-wave displacement warp over an on-chip frame store.
// req channel: tuser is func (0 load, 1 fetch); tdata carries coord_x, coord_y
// and pixel_in. A load writes pixel_in into the store and returns nothing; a
// fetch returns one word on rsp: tdata is the warped BGRA pixel, tuser the
// covered flag (pixel is zero when the displaced sample misses the source).
// csr channel writes one register per word, always ready; write it only
// while no fetch is outstanding.
// Pipeline: a fetch passes the angle, sine rom, multiply, round, store read
// and result queue write registers before rsp_tvalid rises; the queue head
// drives rsp directly. Throughput: one word per cycle on both channels while
// ready is high; loads and fetches may be freely interleaved and a fetch
// sees every earlier load, since both access the store at the same stage.
// Stalls: an 8-entry result queue absorbs rsp_tready low; req_tready drops
// once 8 fetches are outstanding and returns as results are taken.
// Reset: registers return to their defaults and the pipeline and queue
// empty; frame store contents are undefined until loaded.
module sine_wave_image_warp
   import swiw_pkg::*;
#(
   parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
   parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // coord_x[9:0], coord_y[19:10], pixel_in[51:20]
   input  logic                    req_tuser,   // func
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [PIXEL_W-1:0]      rsp_tdata,   // pixel_out[31:0]
   output logic                    rsp_tuser,   // covered
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   swiw_cfg_type              cfg_ff, cfg_in;
   swiw_item_type             req_item;
   logic                      req_accept, rsp_accept, fetch_accept;
   logic [QUEUE_W:0]          pending_ff, pending_in;
   logic                      wave_valid;
   swiw_item_type             wave_item;
   logic signed [SHIFT_W-1:0] wave_shift;
   logic                      res_valid;
   swiw_result_type           res_data;
   swiw_result_type           queue_data;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_AMPLITUDE:    cfg_in.amplitude     = $signed(csr_data[AMP_W-1:0]);
            REG_WAVE_STEP:    cfg_in.wave_step     = csr_data[ANGLE_W-1:0];
            REG_PHASE_OFFSET: cfg_in.phase_offset  = csr_data[ANGLE_W-1:0];
            REG_VERTICAL:     cfg_in.vertical_mode = csr_data[0];
            REG_SRC_WIDTH:    cfg_in.source_width  = csr_data[DIM_W-1:0];
            REG_SRC_HEIGHT:   cfg_in.source_height = csr_data[DIM_W-1:0];
            REG_HAS_ALPHA:    cfg_in.has_alpha     = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amplitude     <= '0;
         cfg_ff.wave_step     <= ANGLE_W'(256);
         cfg_ff.phase_offset  <= '0;
         cfg_ff.vertical_mode <= 1'b0;
         cfg_ff.source_width  <= DIM_W'(256);
         cfg_ff.source_height <= DIM_W'(256);
         cfg_ff.has_alpha     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request word unpack
   always_comb begin
      req_item.func = func_type'(req_tuser);
      req_item.x    = req_tdata[COORD_W-1:0];
      req_item.y    = req_tdata[2*COORD_W-1:COORD_W];
      req_item.pix  = req_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];
   end

   // credit count: fetches in flight plus results queued
   always_comb begin
      req_accept   = req_tvalid && req_tready;
      rsp_accept   = rsp_tvalid && rsp_tready;
      fetch_accept = req_accept && (req_item.func == FUNC_FETCH);
      pending_in   = pending_ff + (QUEUE_W + 1)'(fetch_accept) - (QUEUE_W + 1)'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign req_tready = (pending_ff != (QUEUE_W + 1)'(QUEUE_DEPTH));

   swiw_wave #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_wave (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_item   (req_item),
      .cfg       (cfg_ff),
      .out_valid (wave_valid),
      .out_item  (wave_item),
      .out_shift (wave_shift)
   );

   swiw_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (wave_valid),
      .in_item    (wave_item),
      .in_shift   (wave_shift),
      .cfg        (cfg_ff),
      .out_valid  (res_valid),
      .out_result (res_data)
   );

   swiw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop       (rsp_accept),
      .out_valid (rsp_tvalid),
      .out_data  (queue_data)
   );

   assign rsp_tdata = queue_data.pixel;
   assign rsp_tuser = queue_data.covered;

   // outstanding fetches never exceed the queue room
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= (QUEUE_W + 1)'(QUEUE_DEPTH))
      else $error("outstanding fetch count above queue depth");

   // a result on the port always belongs to an outstanding fetch
   a_result_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != '0))
      else $error("result word with no outstanding fetch");

   // an uncovered sample carries a zero pixel
   a_uncovered_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("uncovered result with nonzero pixel");

   // a load takes no result credit
   a_load_no_credit: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_item.func == FUNC_LOAD) && !rsp_accept)
      |=> (pending_ff == $past(pending_ff)))
      else $error("load changed the outstanding fetch count");

endmodule
